/* hdl/lverm_pkg.sv */
// Shared sizes, field widths and helpers for the extent range mapper.
// Used by lverm_mul and lv_extent_range_mapper; depends on nothing.
package lverm_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int MAX_STRIPES  = 4;
   localparam int SEG_W        = $clog2(MAX_SEGMENTS);
   localparam int STR_W        = $clog2(MAX_STRIPES);
   localparam int SEGC_W       = $clog2(MAX_SEGMENTS + 1);
   localparam int STRC_W       = $clog2(MAX_STRIPES + 1);
   localparam int SLOT_TOTAL   = MAX_SEGMENTS * MAX_STRIPES;

   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int REQ_DATA_W = 288;
   localparam int RSP_DATA_W = 136;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_SECTORS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_TOTAL  = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   typedef struct packed {
      logic start;
   } mul_ctl_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_sts_type;

   // Saturates a full product to 64 bits.
   function automatic logic [63:0] sat64(input logic [MUL_P_W-1:0] p);
      logic [63:0] r;
      r = (p[MUL_P_W-1:64] != '0) ? {64{1'b1}} : p[63:0];
      return r;
   endfunction

endpackage

/* hdl/lverm_mul.sv */
// Shared 64 by 25 bit multiplier built from two 32 by 25 bit partial products.
// Depends on lverm_pkg; the product is valid in the cycle in which done is high.
module lverm_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  lverm_pkg::mul_ctl_type          ctl,
   input  logic [lverm_pkg::MUL_A_W-1:0]   op_a,
   input  logic [lverm_pkg::MUL_B_W-1:0]   op_b,
   output lverm_pkg::mul_sts_type          sts
);

   logic [1:0]                      phase_ff;
   logic                            done_ff;
   logic [lverm_pkg::MUL_A_W-1:0]   a_ff;
   logic [lverm_pkg::MUL_B_W-1:0]   b_ff;
   logic [56:0]                     lo_ff;
   logic [56:0]                     hi_ff;
   logic [lverm_pkg::MUL_P_W-1:0]   p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            2'd0: begin
               if (ctl.start) begin
                  phase_ff <= 2'd1;
               end
            end
            2'd1: phase_ff <= 2'd2;
            2'd2: phase_ff <= 2'd3;
            2'd3: begin
               phase_ff <= 2'd0;
               done_ff  <= 1'b1;
            end
            default: phase_ff <= 2'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == 2'd0 && ctl.start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (phase_ff == 2'd1) begin
         lo_ff <= 57'(a_ff[31:0] * b_ff);
      end
      if (phase_ff == 2'd2) begin
         hi_ff <= 57'(a_ff[63:32] * b_ff);
      end
      if (phase_ff == 2'd3) begin
         p_ff <= {hi_ff, 32'd0} + lverm_pkg::MUL_P_W'(lo_ff);
      end
   end

   assign sts.done    = done_ff;
   assign sts.product = p_ff;

endmodule

/* hdl/lv_extent_range_mapper.sv */
// Top level of the extent range mapper: segment and slot tables and the map sequencer.
// Depends on lverm_pkg and lverm_mul.
//
// A load transaction writes one segment table entry and one stripe slot. A map
// transaction walks the segments one after another through a single shared
// multiplier. For each segment examined the multiplier computes its byte bounds.
// A covering segment then reads each of its stripe slots, and each valid stripe
// goes through the multiplier for its sector and then for its address. The walk
// waits whenever the result side holds off. The input is not ready while a map
// is in progress.
module lv_extent_range_mapper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // seg_index, stripe_index, seg_first_extent, seg_extent_total, slot_valid,
   // device_id, device_base_sector, stripe_first_extent, range_start, range_length
   input  logic [lverm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_device, phys_address, piece_length
   output logic [lverm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // unmapped
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [lverm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lverm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEG_RD, ST_SEG_WAIT, ST_MUL_GO, ST_MUL_WAIT, ST_CHECK,
      ST_SLOT_RD, ST_SLOT_WAIT, ST_SLOT_CHK, ST_EMIT, ST_NEXT_SLOT, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MS_LO_A, MS_LO_B, MS_HI_A, MS_HI_B, MS_SECT, MS_ADDR
   } mstep_type;

   localparam int SLOT_W = lverm_pkg::SEG_W + lverm_pkg::STR_W;

   // Field views of the request.
   logic [3:0]  f_seg;
   logic [1:0]  f_str;
   logic [31:0] f_first, f_count, f_sfirst;
   logic        f_valid;
   logic [7:0]  f_dev;
   logic [47:0] f_base;
   logic [62:0] f_start, f_len;

   assign f_seg    = req_tdata[3:0];
   assign f_str    = req_tdata[5:4];
   assign f_first  = req_tdata[37:6];
   assign f_count  = req_tdata[69:38];
   assign f_valid  = req_tdata[70];
   assign f_dev    = req_tdata[78:71];
   assign f_base   = req_tdata[126:79];
   assign f_sfirst = req_tdata[158:127];
   assign f_start  = req_tdata[221:159];
   assign f_len    = req_tdata[284:222];

   // Configuration.
   logic [24:0] ext_sec_ff;
   logic [12:0] sec_bytes_ff;
   logic [4:0]  seg_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_sec_ff   <= 25'd8192;
         sec_bytes_ff <= 13'd512;
         seg_total_ff <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            lverm_pkg::CSR_EXTENT_SECTORS: ext_sec_ff   <= csr_wdata;
            lverm_pkg::CSR_SECTOR_BYTES:   sec_bytes_ff <= csr_wdata[12:0];
            lverm_pkg::CSR_SEGMENT_TOTAL:  seg_total_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Tables.
   logic [31:0] seg_start_mem [lverm_pkg::MAX_SEGMENTS];
   logic [31:0] seg_count_mem [lverm_pkg::MAX_SEGMENTS];
   logic [7:0]  slot_dev_mem  [lverm_pkg::SLOT_TOTAL];
   logic [47:0] slot_base_mem [lverm_pkg::SLOT_TOTAL];
   logic [31:0] slot_ext_mem  [lverm_pkg::SLOT_TOTAL];
   logic [lverm_pkg::SLOT_TOTAL-1:0] slot_valid_ff;

   state_type   state_ff, state_in;
   mstep_type   mstep_ff;
   logic [lverm_pkg::SEGC_W-1:0] seg_ff, segs_ff;
   logic [lverm_pkg::STRC_W-1:0] str_ff;
   logic [63:0] pos_ff, end_ff, lo_ff, hi_ff, tmp_ff, addr_ff;
   logic [57:0] sect_ff;
   logic [31:0] rd_start_ff, rd_count_ff, rd_ext_ff;
   logic [7:0]  rd_dev_ff;
   logic [47:0] rd_base_ff;
   logic        pend_ff;
   logic [7:0]  pend_dev_ff;
   logic [63:0] pend_addr_ff;
   logic [62:0] pend_len_ff;
   logic        rsp_valid_ff, rsp_last_ff, rsp_unmapped_ff;
   logic [7:0]  rsp_dev_ff;
   logic [63:0] rsp_addr_ff;
   logic [62:0] rsp_len_ff;

   logic                  load_ok;
   logic [SLOT_W-1:0]     wr_slot, rd_slot;
   logic                  accept, out_free, spills, rsp_load;
   logic [63:0]           seg_len;
   logic [63:0]           sat_p;
   lverm_pkg::mul_ctl_type mul_ctl;
   lverm_pkg::mul_sts_type mul_sts;
   logic [lverm_pkg::MUL_A_W-1:0] mul_a;
   logic [lverm_pkg::MUL_B_W-1:0] mul_b;

   assign accept   = req_tvalid && req_tready;
   assign load_ok  = (32'(f_seg) < 32'(lverm_pkg::MAX_SEGMENTS)) &&
                     (32'(f_str) < 32'(lverm_pkg::MAX_STRIPES));
   assign wr_slot  = SLOT_W'({f_seg, f_str});
   assign rd_slot  = {seg_ff[lverm_pkg::SEG_W-1:0], str_ff[lverm_pkg::STR_W-1:0]};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = out_free && ((state_ff == ST_EMIT && pend_ff) || state_ff == ST_FINISH);
   assign spills   = end_ff > hi_ff;
   assign seg_len  = spills ? hi_ff - pos_ff : end_ff - pos_ff;
   assign sat_p    = lverm_pkg::sat64(mul_sts.product);

   always_ff @(posedge clock) begin
      if (accept && req_tuser == lverm_pkg::CMD_LOAD && load_ok) begin
         seg_start_mem[f_seg[lverm_pkg::SEG_W-1:0]] <= f_first;
         seg_count_mem[f_seg[lverm_pkg::SEG_W-1:0]] <= f_count;
         slot_dev_mem[wr_slot]  <= f_dev;
         slot_base_mem[wr_slot] <= f_base;
         slot_ext_mem[wr_slot]  <= f_sfirst;
      end
      rd_start_ff <= seg_start_mem[seg_ff[lverm_pkg::SEG_W-1:0]];
      rd_count_ff <= seg_count_mem[seg_ff[lverm_pkg::SEG_W-1:0]];
      rd_dev_ff   <= slot_dev_mem[rd_slot];
      rd_base_ff  <= slot_base_mem[rd_slot];
      rd_ext_ff   <= slot_ext_mem[rd_slot];
   end

   always_comb begin
      mul_a = '0;
      mul_b = ext_sec_ff;
      case (mstep_ff)
         MS_LO_A: mul_a = 64'(rd_start_ff);
         MS_LO_B: begin
            mul_a = tmp_ff;
            mul_b = 25'(sec_bytes_ff);
         end
         MS_HI_A: mul_a = 64'(33'(rd_start_ff) + 33'(rd_count_ff));
         MS_HI_B: begin
            mul_a = tmp_ff;
            mul_b = 25'(sec_bytes_ff);
         end
         MS_SECT: mul_a = 64'(rd_ext_ff);
         MS_ADDR: begin
            mul_a = 64'(sect_ff);
            mul_b = 25'(sec_bytes_ff);
         end
         default: mul_a = '0;
      endcase
   end

   assign mul_ctl.start = (state_ff == ST_MUL_GO);

   lverm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .sts   (mul_sts)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept && req_tuser == lverm_pkg::CMD_MAP) state_in = ST_SEG_RD;
         ST_SEG_RD:    state_in = (seg_ff >= segs_ff) ? ST_FINISH : ST_SEG_WAIT;
         ST_SEG_WAIT:  state_in = ST_MUL_GO;
         ST_MUL_GO:    state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_sts.done) begin
               case (mstep_ff)
                  MS_HI_B: state_in = ST_CHECK;
                  MS_SECT: state_in = ST_MUL_GO;
                  MS_ADDR: state_in = ST_EMIT;
                  default: state_in = ST_MUL_GO;
               endcase
            end
         end
         ST_CHECK: begin
            if (pos_ff >= lo_ff && pos_ff < hi_ff) begin
               state_in = ST_SLOT_RD;
            end else if (lo_ff > end_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SEG_RD;
            end
         end
         ST_SLOT_RD:   state_in = ST_SLOT_WAIT;
         ST_SLOT_WAIT: state_in = ST_SLOT_CHK;
         ST_SLOT_CHK:  state_in = slot_valid_ff[rd_slot] ? ST_MUL_GO : ST_NEXT_SLOT;
         ST_EMIT:      if (!pend_ff || out_free) state_in = ST_NEXT_SLOT;
         ST_NEXT_SLOT: begin
            if (32'(str_ff) == 32'(lverm_pkg::MAX_STRIPES - 1)) begin
               state_in = spills ? ST_SEG_RD : ST_FINISH;
            end else begin
               state_in = ST_SLOT_RD;
            end
         end
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mstep_ff      <= MS_LO_A;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_tuser == lverm_pkg::CMD_LOAD && load_ok) begin
                  slot_valid_ff[wr_slot] <= f_valid;
               end
               if (accept && req_tuser == lverm_pkg::CMD_MAP) begin
                  pos_ff  <= 64'(f_start);
                  end_ff  <= 64'(f_start) + 64'(f_len);
                  seg_ff  <= '0;
                  segs_ff <= (32'(seg_total_ff) > 32'(lverm_pkg::MAX_SEGMENTS)) ?
                             lverm_pkg::SEGC_W'(lverm_pkg::MAX_SEGMENTS) :
                             lverm_pkg::SEGC_W'(seg_total_ff);
                  pend_ff <= 1'b0;
               end
            end
            ST_SEG_WAIT: mstep_ff <= MS_LO_A;
            ST_MUL_WAIT: begin
               if (mul_sts.done) begin
                  case (mstep_ff)
                     MS_LO_A: begin
                        tmp_ff   <= sat_p;
                        mstep_ff <= MS_LO_B;
                     end
                     MS_LO_B: begin
                        lo_ff    <= sat_p;
                        mstep_ff <= MS_HI_A;
                     end
                     MS_HI_A: begin
                        tmp_ff   <= sat_p;
                        mstep_ff <= MS_HI_B;
                     end
                     MS_HI_B: hi_ff <= sat_p;
                     MS_SECT: begin
                        sect_ff  <= 58'(rd_base_ff) + mul_sts.product[57:0];
                        mstep_ff <= MS_ADDR;
                     end
                     MS_ADDR: addr_ff <= mul_sts.product[63:0] + (pos_ff - lo_ff);
                     default: mstep_ff <= MS_LO_A;
                  endcase
               end
            end
            ST_CHECK: begin
               str_ff <= '0;
               if (!(pos_ff >= lo_ff && pos_ff < hi_ff)) begin
                  seg_ff <= seg_ff + 1'b1;
               end
            end
            ST_SLOT_CHK: mstep_ff <= MS_SECT;
            ST_EMIT: begin
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     rsp_last_ff     <= 1'b0;
                     rsp_unmapped_ff <= 1'b0;
                     rsp_dev_ff      <= pend_dev_ff;
                     rsp_addr_ff     <= pend_addr_ff;
                     rsp_len_ff      <= pend_len_ff;
                  end
                  pend_ff      <= 1'b1;
                  pend_dev_ff  <= rd_dev_ff;
                  pend_addr_ff <= addr_ff;
                  pend_len_ff  <= seg_len[62:0];
               end
            end
            ST_NEXT_SLOT: begin
               if (32'(str_ff) == 32'(lverm_pkg::MAX_STRIPES - 1)) begin
                  if (spills) begin
                     pos_ff <= hi_ff;
                     seg_ff <= seg_ff + 1'b1;
                  end
               end else begin
                  str_ff <= str_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_last_ff     <= 1'b1;
                  rsp_unmapped_ff <= !pend_ff;
                  rsp_dev_ff      <= pend_ff ? pend_dev_ff : 8'd0;
                  rsp_addr_ff     <= pend_ff ? pend_addr_ff : 64'd0;
                  rsp_len_ff      <= pend_ff ? pend_len_ff : 63'd0;
                  pend_ff         <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_addr_ff, rsp_dev_ff};
   assign rsp_tuser  = rsp_unmapped_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for lv_extent_range_mapper: loads segment tables, maps byte ranges
// and compares every piece against an in-bench prediction of the mapping.
// Depends on lverm_pkg and the RTL of the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lverm_pkg::*;

   typedef struct {
      logic        command;
      logic [3:0]  seg_index;
      logic [1:0]  stripe_index;
      logic [31:0] seg_first;
      logic [31:0] seg_total_ext;
      logic        slot_valid;
      logic [7:0]  device_id;
      logic [47:0] base_sector;
      logic [31:0] stripe_first;
      logic [62:0] range_start;
      logic [62:0] range_length;
   } range_cmd_type;

   typedef struct {
      logic [7:0]  device;
      logic [63:0] address;
      logic [62:0] length;
      logic        unmapped;
      logic        last_piece;
   } piece_type;

   class piece_predictor;
      logic [24:0] extent_sectors;
      logic [12:0] sector_bytes;
      logic [4:0]  segments_used;
      logic [31:0] seg_lead_ext[MAX_SEGMENTS];
      logic [31:0] seg_count[MAX_SEGMENTS];
      logic        slot_valid[SLOT_TOTAL];
      logic [7:0]  slot_device[SLOT_TOTAL];
      logic [47:0] slot_base[SLOT_TOTAL];
      logic [31:0] slot_extent[SLOT_TOTAL];
      piece_type   pending_pieces[$];
      int          failures;

      function void clear();
         extent_sectors = 25'd8192;
         sector_bytes   = 13'd512;
         segments_used  = '0;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         pending_pieces.delete();
         failures = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_EXTENT_SECTORS: extent_sectors = value;
            CSR_SECTOR_BYTES:   sector_bytes   = value[12:0];
            CSR_SEGMENT_TOTAL:  segments_used  = value[4:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = 128'(a) * 128'(b);
         return (p[127:64] != '0) ? {64{1'b1}} : p[63:0];
      endfunction

      function logic [63:0] extent_bytes(logic [63:0] ext);
         return sat_mul(sat_mul(ext, 64'(extent_sectors)), 64'(sector_bytes));
      endfunction

      function void note_request(range_cmd_type r);
         int          slot;
         int          segs;
         bit          spills;
         logic [63:0] pos, finish, lo, hi, plen, sect;
         piece_type   p;
         piece_type   found[$];
         if (r.command == CMD_LOAD) begin
            slot = int'(r.seg_index) * MAX_STRIPES + int'(r.stripe_index);
            seg_lead_ext[r.seg_index] = r.seg_first;
            seg_count[r.seg_index]    = r.seg_total_ext;
            slot_valid[slot]  = r.slot_valid;
            slot_device[slot] = r.device_id;
            slot_base[slot]   = r.base_sector;
            slot_extent[slot] = r.stripe_first;
            return;
         end
         pos    = 64'(r.range_start);
         finish = pos + 64'(r.range_length);
         segs   = (int'(segments_used) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(segments_used);
         for (int s = 0; s < segs; s++) begin
            lo = extent_bytes(64'(seg_lead_ext[s]));
            hi = extent_bytes(64'(seg_lead_ext[s]) + 64'(seg_count[s]));
            if (pos >= lo && pos < hi) begin
               spills = finish > hi;
               plen   = spills ? hi - pos : finish - pos;
               for (int k = 0; k < MAX_STRIPES; k++) begin
                  slot = s * MAX_STRIPES + k;
                  if (slot_valid[slot]) begin
                     sect = 64'(slot_base[slot]) + 64'(slot_extent[slot]) * 64'(extent_sectors);
                     p.device     = slot_device[slot];
                     p.address    = sect * 64'(sector_bytes) + (pos - lo);
                     p.length     = plen[62:0];
                     p.unmapped   = 1'b0;
                     p.last_piece = 1'b0;
                     found = {found, p};
                  end
               end
               if (!spills) break;
               pos = hi;
            end else if (lo > finish) begin
               break;
            end
         end
         if (found.size() == 0) begin
            p = '{8'd0, 64'd0, 63'd0, 1'b1, 1'b1};
            found = {found, p};
         end else begin
            found[found.size()-1].last_piece = 1'b1;
         end
         foreach (found[i]) pending_pieces = {pending_pieces, found[i]};
      endfunction

      function void check_piece(piece_type got);
         piece_type want;
         if (pending_pieces.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected piece: device %0d address %h", got.device, got.address);
            return;
         end
         want = pending_pieces.pop_front();
         if (got.device !== want.device || got.address !== want.address ||
             got.length !== want.length || got.unmapped !== want.unmapped ||
             got.last_piece !== want.last_piece) begin
            failures++;
            if (failures <= 10)
               $display("piece mismatch: expected %h %h %h %b %b, got %h %h %h %b %b",
                        want.device, want.address, want.length, want.unmapped,
                        want.last_piece, got.device, got.address, got.length,
                        got.unmapped, got.last_piece);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   piece_predictor mapper_model;
   bit             steady;
   int             hold_cycles;
   logic [31:0]    layout_first[MAX_SEGMENTS];
   logic [31:0]    layout_count[MAX_SEGMENTS];

   lv_extent_range_mapper i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int stall;
      int r;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            r = $urandom_range(0, 99);
            rsp_tready <= 1'b1;
            if (!steady && r >= 70)
               stall = (r >= 96) ? $urandom_range(15, 50) : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mapper_model.check_piece('{rsp_tdata[7:0], rsp_tdata[71:8], rsp_tdata[134:72],
                                    rsp_tuser, rsp_tlast});
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      mapper_model.set_reg(idx, value);
   endtask

   task automatic send(range_cmd_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.command;
      req_tdata  <= {3'b0, r.range_length, r.range_start, r.stripe_first, r.base_sector,
                     r.device_id, r.slot_valid, r.seg_total_ext, r.seg_first,
                     r.stripe_index, r.seg_index};
      do @(posedge clock); while (!req_tready);
      mapper_model.note_request(r);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mapper_model.pending_pieces.size() != 0);
      repeat (60) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic range_cmd_type slot_load(int s);
      range_cmd_type r;
      r.command       = CMD_LOAD;
      r.seg_index     = 4'(s);
      r.stripe_index  = 2'($urandom_range(0, 3));
      r.seg_first     = layout_first[s];
      r.seg_total_ext = layout_count[s];
      r.slot_valid    = ($urandom_range(0, 3) != 0);
      r.device_id     = 8'($urandom);
      r.base_sector   = 48'({$urandom, $urandom});
      r.stripe_first  = $urandom;
      r.range_start   = 63'({$urandom, $urandom});
      r.range_length  = 63'({$urandom, $urandom});
      return r;
   endfunction

   function automatic range_cmd_type range_map(logic [62:0] start, logic [62:0] length);
      range_cmd_type r;
      r = slot_load(0);
      r.command      = CMD_MAP;
      r.range_start  = start;
      r.range_length = length;
      return r;
   endfunction

   task automatic load_layout(bit wide);
      logic [31:0] acc;
      acc = 32'($urandom_range(0, 3));
      for (int s = 0; s < MAX_SEGMENTS; s++) begin
         if (wide) begin
            layout_first[s] = $urandom;
            layout_count[s] = $urandom;
         end else begin
            layout_first[s] = acc;
            layout_count[s] = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
            acc += layout_count[s];
         end
         send(slot_load(s));
      end
      repeat (2) send(slot_load($urandom_range(0, MAX_SEGMENTS - 1)));
   endtask

   task automatic random_traffic(int count);
      int            s, pick, segs;
      logic [63:0]   lo, hi, off, len;
      range_cmd_type r;
      segs = (int'(mapper_model.segments_used) > MAX_SEGMENTS) ? MAX_SEGMENTS
                                                  : int'(mapper_model.segments_used);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send(slot_load($urandom_range(0, MAX_SEGMENTS - 1)));
         end else if (pick < 22 || segs == 0) begin
            send(range_map(63'({$urandom, $urandom}), 63'({$urandom, $urandom})));
         end else begin
            s  = $urandom_range(0, segs - 1);
            lo = mapper_model.extent_bytes(64'(layout_first[s]));
            hi = mapper_model.extent_bytes(64'(layout_first[s]) + 64'(layout_count[s]));
            off = (hi > lo) ? {$urandom, $urandom} % (hi - lo) : 64'd0;
            case ($urandom_range(0, 3))
               0: len = 64'd0;
               1: len = 64'($urandom_range(1, 4096));
               2: len = (hi - lo - off) + 64'($urandom_range(0, 3)) * (hi - lo);
               default: len = {$urandom, $urandom} >> $urandom_range(1, 40);
            endcase
            r = range_map(lo[62:0] + off[62:0], len[62:0]);
            send(r);
         end
      end
   endtask

   initial begin
      range_cmd_type r;
      mapper_model = new();
      mapper_model.clear();
      steady      = 1'b0;
      hold_cycles = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_LOAD;
      csr_we      = 1'b0;
      csr_index   = CSR_EXTENT_SECTORS;
      csr_wdata   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // No segments are walked straight after reset.
      send(range_map(63'd0, 63'd100));
      load_layout(1'b0);
      r = slot_load(15);
      r.stripe_index = 2'd3;
      r.slot_valid   = 1'b1;
      r.device_id    = 8'hff;
      r.base_sector  = {48{1'b1}};
      r.stripe_first = 32'hffff_ffff;
      send(r);
      r = slot_load(0);
      r.stripe_index = 2'd0;
      r.slot_valid   = 1'b1;
      r.device_id    = 8'h00;
      r.base_sector  = '0;
      r.stripe_first = '0;
      send(r);
      settle();
      write_reg(CSR_SEGMENT_TOTAL, 25'd16);
      send(range_map(63'd0, 63'd0));
      send(range_map(63'd0, {63{1'b1}}));
      send(range_map({63{1'b1}}, {63{1'b1}}));
      send(range_map(63'd4194304 * 3 + 63'd17, 63'd0));
      send(range_map(63'd4194304 * 200, 63'd4096));
      send(range_map(63'd4194304 - 63'd1, 63'd4194304 * 3));
      settle();

      write_reg(CSR_EXTENT_SECTORS, 25'd1);
      write_reg(CSR_SECTOR_BYTES, 25'd4096);
      write_reg(CSR_SEGMENT_TOTAL, 25'd16);
      load_layout(1'b0);
      hold_cycles = 400;
      random_traffic(12);
      settle();

      write_reg(CSR_EXTENT_SECTORS, 25'd16777216);
      write_reg(CSR_SECTOR_BYTES, 25'd512);
      write_reg(CSR_SEGMENT_TOTAL, 25'($urandom_range(1, 16)));
      load_layout(1'b1);
      random_traffic(12);
      settle();

      steady = 1'b1;
      write_reg(CSR_EXTENT_SECTORS, 25'($urandom_range(1, 16777216)));
      write_reg(CSR_SECTOR_BYTES, 25'($urandom_range(512, 4096)));
      write_reg(CSR_SEGMENT_TOTAL, 25'd16);
      load_layout(1'b0);
      random_traffic(6);
      steady = 1'b0;
      random_traffic(6);
      settle();

      if (mapper_model.failures == 0 && mapper_model.pending_pieces.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
